FILE: hw/rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and codes for the fit policy block allocator
// Status, policy and action codes, register indexes, the state enum and the cell command struct.
// ----------------------------------------------------------------------------
package fpba_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_WORST = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_POOL_SIZE  = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_DONE
    } state_t;

    // Shift command applied by every cell of a table in the same cycle.
    typedef struct packed {
        logic        init;     // clear table, load entry zero
        logic        push;     // shift everything one place back, load front
        logic        remove;   // close the gap at the selected position
        logic        update;   // overwrite the selected entry
    } cell_cmd_t;

endpackage

FILE: hw/rtl/fpba_if.sv
// ----------------------------------------------------------------------------
// fpba_if: valid/ready channels for the fit policy block allocator
// Request, result and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface fpba_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] req_size;
    logic [15:0] address;
    modport source (output valid, action, req_size, address, input ready);
    modport sink   (input valid, action, req_size, address, output ready);
endinterface

interface fpba_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] address_res;
    modport source (output valid, status, address_res, input ready);
    modport sink   (input valid, status, address_res, output ready);
endinterface

interface fpba_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first, worst or best fit free list allocator
// Two ordered tables of (offset, size) cells, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Flow: an accepted request scans its table (the free table for an allocate,
// stopping at the first fit under first fit; the used table for a deallocate,
// stopping at the match), then decides and, on success, shifts the tables before
// the result is offered; one that finds nothing or a full table skips the shift.
// Throughput: one transaction at a time, the next accepted in the cycle after the
// result is taken. Reset: asynchronous; best fit, pool 65535, one free block.
module fit_policy_block_allocator #(
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fpba_req_if.sink   req,
    fpba_res_if.source res,
    fpba_cfg_if.sink   cfg
);
    localparam int FI_BITS  = $clog2(FREE_ENTRIES);
    localparam int UI_BITS  = $clog2(USED_ENTRIES);
    localparam int FC_BITS  = $clog2(FREE_ENTRIES + 1);
    localparam int UC_BITS  = $clog2(USED_ENTRIES + 1);
    localparam int CNT_BITS = (FC_BITS > UC_BITS) ? FC_BITS : UC_BITS;
    localparam int PI_BITS  = (FI_BITS > UI_BITS) ? FI_BITS : UI_BITS;

    fpba_pkg::state_t state_reg, state_next;

    logic [1:0]         policy_reg;
    logic [15:0]        pool_reg;
    logic [FC_BITS-1:0] fcnt_reg, fcnt_next;
    logic [UC_BITS-1:0] ucnt_reg, ucnt_next;

    // Latched request.
    logic                 act_reg;
    logic [15:0]          want_reg;
    logic [ADDR_BITS-1:0] where_reg;

    // Scan state: position being looked at and the best candidate so far.
    logic [CNT_BITS-1:0]  pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [PI_BITS-1:0]   pick_reg, pick_next;
    logic [15:0]          psize_reg, psize_next;
    logic [ADDR_BITS-1:0] poff_reg, poff_next;

    logic [1:0]           st_reg, st_next;
    logic [15:0]          ares_reg, ares_next;
    logic                 phase_reg, phase_next;  // unused; held at zero

    fpba_pkg::cell_cmd_t  fcmd, ucmd;
    logic [FI_BITS-1:0]   fsel;
    logic [UI_BITS-1:0]   usel;
    logic [ADDR_BITS-1:0] fload_off, uload_off;
    logic [15:0]          fload_size, uload_size;
    logic [ADDR_BITS-1:0] f_rd_off, u_rd_off;
    logic [15:0]          f_rd_size, u_rd_size;

    logic cfg_fire, req_fire, res_fire, fit, better, pool_wr;
    logic [15:0] remain;

    assign cfg_fire = cfg.valid && cfg.ready;
    assign req_fire = req.valid && req.ready;
    assign res_fire = res.valid && res.ready;
    assign pool_wr  = cfg_fire && (cfg.index == fpba_pkg::REG_POOL_SIZE);
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == fpba_pkg::S_IDLE);
    assign res.valid = (state_reg == fpba_pkg::S_DONE);
    assign res.status = st_reg;
    assign res.address_res = ares_reg;

    fpba_table #(.ENTRIES(FREE_ENTRIES), .ADDR_BITS(ADDR_BITS), .IDX_BITS(FI_BITS))
    u_free (
        .clk(clk), .cmd(fcmd), .sel(fsel),
        .init_off('0), .init_size(pool_wr ? cfg.data : pool_reg),
        .load_off(fload_off), .load_size(fload_size),
        .rd_idx(pos_reg[FI_BITS-1:0]), .rd_off(f_rd_off), .rd_size(f_rd_size)
    );

    fpba_table #(.ENTRIES(USED_ENTRIES), .ADDR_BITS(ADDR_BITS), .IDX_BITS(UI_BITS))
    u_used (
        .clk(clk), .cmd(ucmd), .sel(usel),
        .init_off('0), .init_size('0),
        .load_off(uload_off), .load_size(uload_size),
        .rd_idx(pos_reg[UI_BITS-1:0]), .rd_off(u_rd_off), .rd_size(u_rd_size)
    );

    assign fit = (f_rd_size >= want_reg);
    always_comb
    begin
        if (policy_reg == fpba_pkg::POL_WORST) better = f_rd_size > psize_reg;
        else                                  better = f_rd_size < psize_reg;
    end
    assign remain = psize_reg - want_reg;

    // Policy and pool size registers; pool_size writes also reinitialize the tables below.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            policy_reg <= fpba_pkg::POL_BEST;
            pool_reg   <= 16'hFFFF;
        end else if (cfg_fire) begin
            if (cfg.index == fpba_pkg::REG_FIT_POLICY) policy_reg <= cfg.data[1:0];
            else                                      pool_reg   <= cfg.data;
        end
    end

    // Table init right after reset: a one-cycle pending flag.
    logic init_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) init_pend_reg <= 1'b1;
        else        init_pend_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= fpba_pkg::S_IDLE;
            fcnt_reg  <= FC_BITS'(1);
            ucnt_reg  <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            ucnt_reg  <= ucnt_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg  <= pick_next;
        psize_reg <= psize_next;
        poff_reg  <= poff_next;
        st_reg    <= st_next;
        ares_reg  <= ares_next;
        if (req_fire) begin
            act_reg   <= req.action;
            want_reg  <= req.req_size;
            where_reg <= ADDR_BITS'(req.address);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fcnt_next  = fcnt_reg;
        ucnt_next  = ucnt_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        phase_next = phase_reg;
        pick_next  = pick_reg;
        psize_next = psize_reg;
        poff_next  = poff_reg;
        st_next    = st_reg;
        ares_next  = ares_reg;
        fcmd = '0;
        ucmd = '0;
        fsel = '0;
        usel = '0;
        fload_off  = poff_reg;
        fload_size = psize_reg;
        uload_off  = poff_reg;
        uload_size = want_reg;

        unique case (state_reg)
            fpba_pkg::S_IDLE:
            begin
                pos_next   = '0;
                found_next = 1'b0;
                phase_next = 1'b0;
                if (req_fire) state_next = fpba_pkg::S_SCAN;
            end
            fpba_pkg::S_SCAN:
            begin
                if (act_reg == fpba_pkg::ACT_ALLOC) begin
                    if (pos_reg >= CNT_BITS'(fcnt_reg)) begin
                        state_next = fpba_pkg::S_DECIDE;
                    end else begin
                        if (fit && (!found_reg || better)) begin
                            found_next = 1'b1;
                            pick_next  = PI_BITS'(pos_reg);
                            psize_next = f_rd_size;
                            poff_next  = f_rd_off;
                        end
                        if (fit && policy_reg == fpba_pkg::POL_FIRST)
                            state_next = fpba_pkg::S_DECIDE;
                        pos_next = pos_reg + CNT_BITS'(1);
                    end
                end else begin
                    if (pos_reg >= CNT_BITS'(ucnt_reg) ||
                        pos_reg >= CNT_BITS'(USED_ENTRIES)) begin
                        state_next = fpba_pkg::S_DECIDE;
                    end else if (u_rd_off == where_reg) begin
                        found_next = 1'b1;
                        pick_next  = PI_BITS'(pos_reg);
                        psize_next = u_rd_size;
                        poff_next  = u_rd_off;
                        state_next = fpba_pkg::S_DECIDE;
                    end else begin
                        pos_next = pos_reg + CNT_BITS'(1);
                    end
                end
            end
            fpba_pkg::S_DECIDE:
            begin
                ares_next  = '0;
                state_next = fpba_pkg::S_DONE;
                if (!found_reg) begin
                    st_next = (act_reg == fpba_pkg::ACT_ALLOC) ? fpba_pkg::ST_NOFIT
                                                               : fpba_pkg::ST_NOTFOUND;
                end else if (act_reg == fpba_pkg::ACT_ALLOC &&
                             ucnt_reg >= UC_BITS'(USED_ENTRIES)) begin
                    st_next = fpba_pkg::ST_FULL;
                end else if (act_reg != fpba_pkg::ACT_ALLOC &&
                             fcnt_reg >= FC_BITS'(FREE_ENTRIES)) begin
                    st_next = fpba_pkg::ST_FULL;
                end else begin
                    st_next    = fpba_pkg::ST_OK;
                    if (act_reg == fpba_pkg::ACT_ALLOC) ares_next = 16'(poff_reg);
                    state_next = fpba_pkg::S_SHIFT;
                end
            end
            fpba_pkg::S_SHIFT:
            begin
                if (act_reg == fpba_pkg::ACT_ALLOC) begin
                    fsel = FI_BITS'(pick_reg);
                    fload_off  = poff_reg + ADDR_BITS'(want_reg);
                    fload_size = remain;
                    if (remain == 16'd0) begin
                        fcmd.remove = 1'b1;
                        fcnt_next   = fcnt_reg - FC_BITS'(1);
                    end else begin
                        fcmd.update = 1'b1;
                    end
                    ucmd.push = 1'b1;
                    ucnt_next = ucnt_reg + UC_BITS'(1);
                end else begin
                    usel = UI_BITS'(pick_reg);
                    ucmd.remove = 1'b1;
                    ucnt_next   = ucnt_reg - UC_BITS'(1);
                    fcmd.push   = 1'b1;
                    fcnt_next   = fcnt_reg + FC_BITS'(1);
                    fload_size  = psize_reg;
                end
                state_next = fpba_pkg::S_DONE;
            end
            fpba_pkg::S_DONE:
            begin
                if (res_fire) state_next = fpba_pkg::S_IDLE;
            end
            default: state_next = fpba_pkg::S_IDLE;
        endcase

        // Reinitialization wins over table activity; user lets it occur idle (unenforced).
        if (init_pend_reg || pool_wr) begin
            fcmd = '0;
            ucmd = '0;
            fcmd.init = 1'b1;
            fcnt_next = FC_BITS'(1);
            ucnt_next = '0;
        end
    end

`ifndef SYNTHESIS
    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FC_BITS'(FREE_ENTRIES))
        else $error("free count beyond table depth");
    a_ucnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ucnt_reg <= UC_BITS'(USED_ENTRIES))
        else $error("used count beyond table depth");
    a_ok_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::S_SHIFT) |=> (ucnt_reg != $past(ucnt_reg)))
        else $error("successful transaction did not change used count");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != fpba_pkg::ST_OK) |-> (res.address_res == 16'd0))
        else $error("failed transaction returned an address");
`endif
endmodule

FILE: hw/rtl/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell: one table entry of offset and size
// Holds one entry and moves it to or from its neighbors on a table command.
// ----------------------------------------------------------------------------
module fpba_cell #(
    parameter int ADDR_BITS = 16
) (
    input  logic                   clk,
    input  fpba_pkg::cell_cmd_t    cmd,
    input  logic                   is_sel,     // this is the selected position
    input  logic                   after_sel,  // position lies behind the selection
    input  logic [ADDR_BITS-1:0]   init_off,
    input  logic [15:0]            init_size,
    input  logic [ADDR_BITS-1:0]   load_off,   // front load or update value
    input  logic [15:0]            load_size,
    input  logic [ADDR_BITS-1:0]   prev_off,
    input  logic [15:0]            prev_size,
    input  logic [ADDR_BITS-1:0]   next_off,
    input  logic [15:0]            next_size,
    output logic [ADDR_BITS-1:0]   off,
    output logic [15:0]            size
);
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [15:0]          size_reg, size_next;

    always_comb
    begin
        off_next  = off_reg;
        size_next = size_reg;
        if (cmd.init) begin
            off_next  = init_off;
            size_next = init_size;
        end else if (cmd.push) begin
            off_next  = prev_off;
            size_next = prev_size;
            if (is_sel) begin
                off_next  = load_off;
                size_next = load_size;
            end
        end else if (cmd.remove) begin
            if (is_sel || after_sel) begin
                off_next  = next_off;
                size_next = next_size;
            end
        end else if (cmd.update && is_sel) begin
            off_next  = load_off;
            size_next = load_size;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        size_reg <= size_next;
    end

    assign off  = off_reg;
    assign size = size_reg;
endmodule

FILE: hw/rtl/fpba_table.sv
// ----------------------------------------------------------------------------
// fpba_table: row of entry cells forming one ordered table
// Chains the cells so that pushes and removals shift data by one place.
// ----------------------------------------------------------------------------
module fpba_table #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 16,
    parameter int IDX_BITS  = 4
) (
    input  logic                  clk,
    input  fpba_pkg::cell_cmd_t   cmd,
    input  logic [IDX_BITS-1:0]   sel,
    input  logic [ADDR_BITS-1:0]  init_off,
    input  logic [15:0]           init_size,
    input  logic [ADDR_BITS-1:0]  load_off,
    input  logic [15:0]           load_size,
    input  logic [IDX_BITS-1:0]   rd_idx,
    output logic [ADDR_BITS-1:0]  rd_off,
    output logic [15:0]           rd_size
);
    logic [ADDR_BITS-1:0] offs  [ENTRIES];
    logic [15:0]          sizes [ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [ADDR_BITS-1:0] p_off, n_off, i_off;
        logic [15:0]          p_size, n_size, i_size;
        if (g == 0) begin : g_front
            assign p_off  = load_off;
            assign p_size = load_size;
            assign i_off  = init_off;
            assign i_size = init_size;
        end else begin : g_mid
            assign p_off  = offs[g-1];
            assign p_size = sizes[g-1];
            assign i_off  = '0;
            assign i_size = '0;
        end
        if (g == ENTRIES - 1) begin : g_back
            assign n_off  = '0;
            assign n_size = '0;
        end else begin : g_inner
            assign n_off  = offs[g+1];
            assign n_size = sizes[g+1];
        end
        fpba_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .is_sel    (sel == IDX_BITS'(g)),
            .after_sel (IDX_BITS'(g) > sel),
            .init_off  (i_off),
            .init_size (i_size),
            .load_off  (load_off),
            .load_size (load_size),
            .prev_off  (p_off),
            .prev_size (p_size),
            .next_off  (n_off),
            .next_size (n_size),
            .off       (offs[g]),
            .size      (sizes[g])
        );
    end

    assign rd_off  = offs[rd_idx];
    assign rd_size = sizes[rd_idx];
endmodule
